### rtl/sps_pkg.sv
// Shared types and constants for the segment program sequencer.
package sps_pkg;

    // Default segment table depth
    localparam int MAX_SEGMENTS_DEF = 16;

    // Field widths fixed by the interface
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 4;
    localparam int HH_W      = 7;
    localparam int MM_W      = 6;
    localparam int SS_W      = 6;
    localparam int TEMP_W    = 14;
    localparam int TOTAL_W   = 5;
    localparam int DUR_W     = 19;
    localparam int TARGET_W  = 23;
    localparam int HOURS_W   = 16;
    localparam int ELAPSED_W = 28;
    localparam int SEGOUT_W  = 5;

    localparam logic [TARGET_W-1:0] TARGET_MAX  = {TARGET_W{1'b1}};
    localparam logic [HOURS_W-1:0]  HOURS_MAX   = {HOURS_W{1'b1}};
    localparam logic [MM_W-1:0]     MINUTE_LAST = MM_W'(59);
    localparam logic [SS_W-1:0]     SECOND_LAST = SS_W'(59);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_DONE   = 2'd2
    } t_run;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // Segment table write request
    typedef struct packed {
        logic              en;
        logic [DUR_W-1:0]  dur;
        logic [TEMP_W-1:0] temp;
    } t_tbl_wr;

endpackage

### rtl/sps_alu.sv
// Shared add/subtract unit used for target accumulation and elapsed-vs-target compare.
module sps_alu #(
    parameter int W = sps_pkg::ELAPSED_W
) (
    input  sps_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W:0]       o_res
);

    // Add or subtract with the carry/borrow kept in the top bit
    always_comb begin
        if (i_op == sps_pkg::ALU_ADD) begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end
    end

endmodule

### rtl/sps_table.sv
// Segment duration and setpoint table with per-entry valid bits and registered read.
module sps_table #(
    parameter int DEPTH = sps_pkg::MAX_SEGMENTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sps_pkg::t_tbl_wr              i_wr,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [sps_pkg::DUR_W-1:0]     o_rd_dur,
    output logic [sps_pkg::TEMP_W-1:0]    o_rd_temp
);

    logic [DEPTH-1:0]               r_valid;
    logic [sps_pkg::DUR_W-1:0]      r_dur_mem  [DEPTH];
    logic [sps_pkg::TEMP_W-1:0]     r_temp_mem [DEPTH];
    logic [sps_pkg::DUR_W-1:0]      r_rd_dur;
    logic [sps_pkg::TEMP_W-1:0]     r_rd_temp;

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_dur_mem[i_wr_addr]  <= i_wr.dur;
            r_temp_mem[i_wr_addr] <= i_wr.temp;
        end
    end

    // Registered read; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (r_valid[i_rd_addr]) begin
                r_rd_dur  <= r_dur_mem[i_rd_addr];
                r_rd_temp <= r_temp_mem[i_rd_addr];
            end else begin
                r_rd_dur  <= '0;
                r_rd_temp <= '0;
            end
        end
    end

    assign o_rd_dur  = r_rd_dur;
    assign o_rd_temp = r_rd_temp;

endmodule

### rtl/segment_program_sequencer.sv
// Segment program sequencer: top level with command sequencer and result register.
// Each item goes from EXEC through CHECK to FIN, which loads the result register; start
// and each segment advance pass through ADD on the way to CHECK, and completing the
// program takes another pass through CHECK. Items are taken one at a time, in IDLE only,
// sharing the add/compare unit and table read port. A stalled result holds off the input.
// Reset: synchronous active low; clears state, table valid bits and output valid at once.
module segment_program_sequencer #(
    parameter int MAX_SEGMENTS = sps_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write: total_segments
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] segment_index, [10:4] seg_hours, [16:11] seg_minutes,
    // [22:17] seg_seconds, [36:23] seg_temp, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] run_state, [6:2] active_segment, [22:7] elapsed_hours,
    // [28:23] elapsed_minutes, [34:29] elapsed_secs, [48:35] setpoint,
    // [49] segment_changed, [55:50] zero
    output logic [55:0] m_axis_tdata
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SW = $clog2(MAX_SEGMENTS + 1);
    localparam int GW = $clog2(MAX_SEGMENTS + 2);
    localparam int EW = sps_pkg::ELAPSED_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_CHECK = 5'b00100,
        S_ADD   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    sps_pkg::t_run                   r_run, n_run;
    logic [SW-1:0]                   r_seg, n_seg;
    logic [GW-1:0]                   r_guard, n_guard;
    logic                            r_changed, n_changed;
    logic [sps_pkg::TARGET_W-1:0]    r_target, n_target;
    logic [EW-1:0]                   r_elapsed, n_elapsed;
    logic [sps_pkg::HOURS_W-1:0]     r_hours, n_hours;
    logic [sps_pkg::MM_W-1:0]        r_minutes, n_minutes;
    logic [sps_pkg::SS_W-1:0]        r_seconds, n_seconds;
    logic [sps_pkg::TOTAL_W-1:0]     r_total;

    sps_pkg::t_cmd                   r_cmd;
    logic [sps_pkg::IDX_W-1:0]       r_idx;
    logic [sps_pkg::HH_W-1:0]        r_hh;
    logic [sps_pkg::MM_W-1:0]        r_mm;
    logic [sps_pkg::SS_W-1:0]        r_ss;
    logic [sps_pkg::TEMP_W-1:0]      r_temp;

    logic                            r_out_valid;
    logic [55:0]                     r_out_data;

    logic                            in_xfer;
    logic                            out_xfer;
    logic                            load_out;

    sps_pkg::t_tbl_wr                tbl_wr;
    logic [AW-1:0]                   tbl_wr_addr;
    logic                            tbl_rd_en;
    logic [AW-1:0]                   tbl_rd_addr;
    logic [sps_pkg::DUR_W-1:0]       tbl_rd_dur;
    logic [sps_pkg::TEMP_W-1:0]      tbl_rd_temp;

    sps_pkg::t_alu_op                alu_op;
    logic [EW-1:0]                   alu_a;
    logic [EW-1:0]                   alu_b;
    logic [EW:0]                     alu_res;

    logic [19:0]                     dur_sum;
    logic [7:0]                      used_segs;
    logic                            clock_at_limit;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Shared add/compare unit
    sps_alu #(
        .W (EW)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Segment table
    sps_table #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_wr_addr (tbl_wr_addr),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_dur  (tbl_rd_dur),
        .o_rd_temp (tbl_rd_temp)
    );

    // Clamp segment count to 1..MAX_SEGMENTS
    always_comb begin
        if (r_total == '0) begin
            used_segs = 8'd1;
        end else if ({3'b000, r_total} > 8'(MAX_SEGMENTS)) begin
            used_segs = 8'(MAX_SEGMENTS);
        end else begin
            used_segs = {3'b000, r_total};
        end
    end

    // Duration in seconds from the written hours, minutes and seconds
    assign dur_sum = 20'(r_hh) * 20'd3600 + 20'(r_mm) * 20'd60 + 20'(r_ss);

    assign clock_at_limit = (r_hours == sps_pkg::HOURS_MAX)
                         && (r_minutes >= sps_pkg::MINUTE_LAST)
                         && (r_seconds >= sps_pkg::SECOND_LAST);

    // Operand select for the shared unit
    always_comb begin
        if (r_state == S_ADD) begin
            alu_op = sps_pkg::ALU_ADD;
            alu_a  = EW'(r_target);
            alu_b  = EW'(tbl_rd_dur);
        end else begin
            alu_op = sps_pkg::ALU_SUB;
            alu_a  = r_elapsed;
            alu_b  = EW'(r_target);
        end
    end

    // Table write request
    always_comb begin
        tbl_wr.en   = (r_state == S_EXEC) && (r_cmd == sps_pkg::CMD_WRITE)
                   && (r_run != sps_pkg::RUN_ACTIVE)
                   && ({4'b0000, r_idx} < 8'(MAX_SEGMENTS));
        tbl_wr.dur  = dur_sum[sps_pkg::DUR_W-1:0];
        tbl_wr.temp = r_temp;
        tbl_wr_addr = AW'(r_idx);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_seg       = r_seg;
        n_guard     = r_guard;
        n_changed   = r_changed;
        n_target    = r_target;
        n_elapsed   = r_elapsed;
        n_hours     = r_hours;
        n_minutes   = r_minutes;
        n_seconds   = r_seconds;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = '0;
        load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_guard   = '0;
                    n_changed = 1'b0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_CHECK;
                case (r_cmd)
                    sps_pkg::CMD_TICK: begin
                        if (r_run == sps_pkg::RUN_ACTIVE && !clock_at_limit) begin
                            n_elapsed = r_elapsed + 1'b1;
                            if (r_seconds >= sps_pkg::SECOND_LAST) begin
                                n_seconds = '0;
                                if (r_minutes >= sps_pkg::MINUTE_LAST) begin
                                    n_minutes = '0;
                                    n_hours   = r_hours + 1'b1;
                                end else begin
                                    n_minutes = r_minutes + 1'b1;
                                end
                            end else begin
                                n_seconds = r_seconds + 1'b1;
                            end
                        end
                    end
                    sps_pkg::CMD_START: begin
                        n_elapsed   = '0;
                        n_hours     = '0;
                        n_minutes   = '0;
                        n_seconds   = '0;
                        n_seg       = SW'(1);
                        n_run       = sps_pkg::RUN_ACTIVE;
                        n_target    = '0;
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = '0;
                        n_state     = S_ADD;
                    end
                    sps_pkg::CMD_STOP: begin
                        n_run = sps_pkg::RUN_IDLE;
                    end
                    default: begin
                        // table write is driven from the request logic
                    end
                endcase
            end
            S_CHECK: begin
                // Advance while elapsed time has reached the cumulative target
                if (r_run == sps_pkg::RUN_ACTIVE && !alu_res[EW]
                        && (r_guard <= GW'(MAX_SEGMENTS))) begin
                    n_guard   = r_guard + 1'b1;
                    n_changed = 1'b1;
                    if ({{(8 - SW){1'b0}}, r_seg} < used_segs) begin
                        n_seg       = r_seg + 1'b1;
                        tbl_rd_en   = 1'b1;
                        tbl_rd_addr = AW'(r_seg);
                        n_state     = S_ADD;
                    end else begin
                        n_run = sps_pkg::RUN_DONE;
                    end
                end else begin
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = AW'(r_seg - 1'b1);
                    n_state     = S_FIN;
                end
            end
            S_ADD: begin
                // Accumulate the new segment's duration, saturating
                if (alu_res > (EW + 1)'(sps_pkg::TARGET_MAX)) begin
                    n_target = sps_pkg::TARGET_MAX;
                end else begin
                    n_target = alu_res[sps_pkg::TARGET_W-1:0];
                end
                n_state = S_CHECK;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= sps_pkg::RUN_IDLE;
            r_seg     <= SW'(1);
            r_guard   <= '0;
            r_changed <= 1'b0;
            r_target  <= '0;
            r_elapsed <= '0;
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
        end else begin
            r_state   <= n_state;
            r_run     <= n_run;
            r_seg     <= n_seg;
            r_guard   <= n_guard;
            r_changed <= n_changed;
            r_target  <= n_target;
            r_elapsed <= n_elapsed;
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

    // Segment count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= sps_pkg::TOTAL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_total <= i_cfg_data;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= sps_pkg::t_cmd'(s_axis_tuser);
            r_idx  <= s_axis_tdata[3:0];
            r_hh   <= s_axis_tdata[10:4];
            r_mm   <= s_axis_tdata[16:11];
            r_ss   <= s_axis_tdata[22:17];
            r_temp <= s_axis_tdata[36:23];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {6'b000000, r_changed, tbl_rd_temp, r_seconds, r_minutes,
                           r_hours, sps_pkg::SEGOUT_W'(r_seg), r_run};
        end
    end

endmodule

### rtl/sps_checker.sv
// Port-level checker for the segment program sequencer, bound to the top level.
module sps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A stopped program never reports a segment change
    a_idle_nochange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == sps_pkg::RUN_IDLE) |-> !m_axis_tdata[49])
        else $error("segment change reported while idle");

    // Active segment number is one-based
    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:2] != 5'd0))
        else $error("active segment is zero");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind segment_program_sequencer sps_checker u_sps_checker (.*);

### verif/segment_program_sequencer_tb.sv
// Self-checking testbench for the segment program sequencer: status predictor and stream drivers.

// Predict the status word of every accepted command and check the block's results against it
class status_scoreboard;
    typedef struct packed {
        logic                         changed;
        logic [sps_pkg::TEMP_W-1:0]   setpoint;
        logic [sps_pkg::SS_W-1:0]     secs;
        logic [sps_pkg::MM_W-1:0]     mins;
        logic [sps_pkg::HOURS_W-1:0]  hours;
        logic [sps_pkg::SEGOUT_W-1:0] seg;
        logic [1:0]                   state;
    } t_status;

    logic [sps_pkg::DUR_W-1:0]    dur_tab[sps_pkg::MAX_SEGMENTS_DEF];
    logic [sps_pkg::TEMP_W-1:0]   temp_tab[sps_pkg::MAX_SEGMENTS_DEF];
    logic [sps_pkg::HOURS_W-1:0]  hours;
    logic [sps_pkg::MM_W-1:0]     mins;
    logic [sps_pkg::SS_W-1:0]     secs;
    logic [sps_pkg::TARGET_W-1:0] target;
    logic [sps_pkg::SEGOUT_W-1:0] seg_num;
    sps_pkg::t_run                run;
    logic [sps_pkg::TOTAL_W-1:0]  seg_total;
    t_status                      status_q[$];
    int                           errors;
    int                           results;
    int                           advances;
    int                           completions;
    int                           settings;

    function new();
        for (int i = 0; i < sps_pkg::MAX_SEGMENTS_DEF; i++) begin
            dur_tab[i]  = '0;
            temp_tab[i] = '0;
        end
        hours       = '0;
        mins        = '0;
        secs        = '0;
        target      = '0;
        seg_num     = sps_pkg::SEGOUT_W'(1);
        run         = sps_pkg::RUN_IDLE;
        seg_total   = sps_pkg::TOTAL_W'(1);
        errors      = 0;
        results     = 0;
        advances    = 0;
        completions = 0;
        settings    = 0;
    endfunction

    function void set_total(logic [sps_pkg::TOTAL_W-1:0] value);
        seg_total = value;
        settings++;
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    // Clamp the segment count into 1..table depth
    function int unsigned segments_in_use();
        if (seg_total < 1) return 1;
        if (seg_total > sps_pkg::MAX_SEGMENTS_DEF) return sps_pkg::MAX_SEGMENTS_DEF;
        return seg_total;
    endfunction

    function logic [sps_pkg::DUR_W-1:0] duration_of(int unsigned number);
        if (number < 1 || number > sps_pkg::MAX_SEGMENTS_DEF) return '0;
        return dur_tab[number - 1];
    endfunction

    function logic [sps_pkg::TEMP_W-1:0] setpoint_of(int unsigned number);
        if (number < 1 || number > sps_pkg::MAX_SEGMENTS_DEF) return '0;
        return temp_tab[number - 1];
    endfunction

    // Add to the cumulative target, saturating at its maximum
    function void extend_target(logic [sps_pkg::DUR_W-1:0] dur);
        logic [sps_pkg::TARGET_W:0] sum;
        sum = {1'b0, target} + (sps_pkg::TARGET_W + 1)'(dur);
        target = (sum > {1'b0, sps_pkg::TARGET_MAX}) ? sps_pkg::TARGET_MAX
                                                     : sum[sps_pkg::TARGET_W-1:0];
    endfunction

    // Advance the run clock by one second, holding at its limit
    function void tick_clock();
        int unsigned s;
        int unsigned m;
        if (hours >= sps_pkg::HOURS_MAX && mins >= sps_pkg::MINUTE_LAST &&
            secs >= sps_pkg::SECOND_LAST) return;
        s = secs + 1;
        m = mins;
        if (s >= 60) begin
            s = 0;
            m++;
            if (m >= 60) begin
                m = 0;
                hours++;
            end
        end
        secs = sps_pkg::SS_W'(s);
        mins = sps_pkg::MM_W'(m);
    endfunction

    function void take_command(sps_pkg::t_cmd cmd, logic [sps_pkg::IDX_W-1:0] idx,
                               logic [sps_pkg::HH_W-1:0] hh,
                               logic [sps_pkg::MM_W-1:0] mm,
                               logic [sps_pkg::SS_W-1:0] ss,
                               logic [sps_pkg::TEMP_W-1:0] tp);
        int unsigned     dur;
        longint unsigned elapsed;
        int              guard;
        logic            changed;
        t_status         st;
        case (cmd)
            sps_pkg::CMD_TICK: begin
                if (run == sps_pkg::RUN_ACTIVE) tick_clock();
            end
            sps_pkg::CMD_START: begin
                hours   = '0;
                mins    = '0;
                secs    = '0;
                seg_num = sps_pkg::SEGOUT_W'(1);
                run     = sps_pkg::RUN_ACTIVE;
                target  = '0;
                extend_target(dur_tab[0]);
            end
            sps_pkg::CMD_STOP: begin
                run = sps_pkg::RUN_IDLE;
            end
            default: begin
                // table writes only land outside a run
                if (run != sps_pkg::RUN_ACTIVE) begin
                    dur = 32'(hh) * 3600 + 32'(mm) * 60 + 32'(ss);
                    dur_tab[idx]  = dur[sps_pkg::DUR_W-1:0];
                    temp_tab[idx] = tp;
                end
            end
        endcase

        // pass over every segment whose cumulative target has been reached
        changed = 1'b0;
        guard   = 0;
        elapsed = longint'(hours) * 3600 + longint'(mins) * 60 + longint'(secs);
        while (run == sps_pkg::RUN_ACTIVE && elapsed >= target &&
               guard <= sps_pkg::MAX_SEGMENTS_DEF) begin
            guard++;
            changed = 1'b1;
            if (seg_num < segments_in_use()) begin
                seg_num++;
                extend_target(duration_of(seg_num));
                advances++;
            end else begin
                run = sps_pkg::RUN_DONE;
                completions++;
            end
        end

        st.state    = run;
        st.seg      = seg_num;
        st.hours    = hours;
        st.mins     = mins;
        st.secs     = secs;
        st.setpoint = setpoint_of(seg_num);
        st.changed  = changed;
        status_q.push_back(st);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_status(logic [55:0] word);
        t_status got;
        t_status want;
        got = word[49:0];
        if (status_q.size() == 0) begin
            $error("result %h arrived with no command pending", word);
            errors++;
            return;
        end
        want = status_q.pop_front();
        results++;
        compare_field("run_state", 32'(want.state), 32'(got.state));
        compare_field("active_segment", 32'(want.seg), 32'(got.seg));
        compare_field("elapsed_hours", 32'(want.hours), 32'(got.hours));
        compare_field("elapsed_minutes", 32'(want.mins), 32'(got.mins));
        compare_field("elapsed_secs", 32'(want.secs), 32'(got.secs));
        compare_field("setpoint", 32'(want.setpoint), 32'(got.setpoint));
        compare_field("segment_changed", 32'(want.changed), 32'(got.changed));
    endfunction
endclass

module segment_program_sequencer_tb;
    localparam int CLK_HALF       = 6;
    localparam int IDLE_MAX       = 9;
    localparam int STALL_LEN      = 160;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1650;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [4:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [55:0] m_axis_tdata;

    status_scoreboard board = new();
    bit tx_no_gaps   = 1'b0;
    bit rx_no_gaps   = 1'b0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    segment_program_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Present one command and hold it until the transfer; call at a falling edge
    task automatic send_item(sps_pkg::t_cmd cmd, logic [sps_pkg::IDX_W-1:0] idx,
                             logic [sps_pkg::HH_W-1:0] hh,
                             logic [sps_pkg::MM_W-1:0] mm,
                             logic [sps_pkg::SS_W-1:0] ss,
                             logic [sps_pkg::TEMP_W-1:0] tp);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, tp, ss, mm, hh, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_command(cmd, idx, hh, mm, ss, tp);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Non-write commands carry random payload that the block must ignore
    task automatic send_plain(sps_pkg::t_cmd cmd);
        send_item(cmd, sps_pkg::IDX_W'($urandom), sps_pkg::HH_W'($urandom),
                  sps_pkg::MM_W'($urandom), sps_pkg::SS_W'($urandom),
                  sps_pkg::TEMP_W'($urandom));
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_total(logic [sps_pkg::TOTAL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_total(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Write one table entry, mostly short or zero-length so runs reach their end
    task automatic program_segment(int idx);
        logic [sps_pkg::HH_W-1:0] hh;
        logic [sps_pkg::MM_W-1:0] mm;
        logic [sps_pkg::SS_W-1:0] ss;
        int                       pick;
        pick = $urandom_range(0, 99);
        hh = '0;
        mm = '0;
        ss = '0;
        if (pick < 6) begin
            hh = sps_pkg::HH_W'($urandom);
            mm = sps_pkg::MM_W'($urandom);
            ss = sps_pkg::SS_W'($urandom);
        end else if (pick < 35) begin
            ss = '0;
        end else if (pick < 90) begin
            ss = sps_pkg::SS_W'($urandom_range(1, 12));
        end else begin
            mm = sps_pkg::MM_W'(1);
            ss = sps_pkg::SS_W'($urandom);
        end
        send_item(sps_pkg::CMD_WRITE, sps_pkg::IDX_W'(idx), hh, mm, ss,
                  sps_pkg::TEMP_W'($urandom));
    endtask

    // Stop if needed, load the table, start, and tick through with a little noise
    task automatic run_program();
        int n_write;
        int cap;
        int ticks;
        if (board.run == sps_pkg::RUN_ACTIVE) send_plain(sps_pkg::CMD_STOP);
        n_write = $urandom_range(0, board.segments_in_use());
        for (int i = 0; i < n_write; i++) begin
            program_segment(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : i);
        end
        send_plain(sps_pkg::CMD_START);
        cap   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : $urandom_range(40, 250);
        ticks = 0;
        while (board.run == sps_pkg::RUN_ACTIVE && ticks < cap) begin
            if ($urandom_range(0, 99) < 4) send_plain(sps_pkg::t_cmd'($urandom_range(0, 3)));
            else send_plain(sps_pkg::CMD_TICK);
            ticks++;
        end
        repeat ($urandom_range(0, 3)) send_plain(sps_pkg::CMD_TICK);
        if ($urandom_range(0, 3) == 0) send_plain(sps_pkg::CMD_STOP);
    endtask

    // Main stimulus: directed commands, then randomized programs under several settings
    initial begin : stimulus
        logic [sps_pkg::TOTAL_W-1:0] extremes[5];
        logic [sps_pkg::TOTAL_W-1:0] total;
        int                          phase;
        int                          random_goal;
        extremes = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table with one segment: start completes at once
        send_plain(sps_pkg::CMD_TICK);
        send_plain(sps_pkg::CMD_START);
        send_plain(sps_pkg::CMD_TICK);
        send_item(sps_pkg::CMD_WRITE, 4'd0, 7'd0, 6'd0, 6'd3, 14'h3FFF);
        send_item(sps_pkg::CMD_WRITE, 4'd15, 7'd127, 6'd63, 6'd63, 14'd0);
        // restart from completed; a write during the run is dropped
        send_plain(sps_pkg::CMD_START);
        send_item(sps_pkg::CMD_WRITE, 4'd1, 7'd0, 6'd0, 6'd1, 14'd77);
        repeat (3) send_plain(sps_pkg::CMD_TICK);
        send_plain(sps_pkg::CMD_STOP);
        drain();
        write_total(sps_pkg::TOTAL_W'(16));

        // zero-length segments are passed over in one item
        send_item(sps_pkg::CMD_WRITE, 4'd1, 7'd0, 6'd0, 6'd0, 14'd100);
        send_item(sps_pkg::CMD_WRITE, 4'd2, 7'd0, 6'd0, 6'd2, 14'd200);
        send_plain(sps_pkg::CMD_START);
        repeat (5) send_plain(sps_pkg::CMD_TICK);
        send_plain(sps_pkg::CMD_START);
        send_plain(sps_pkg::CMD_TICK);
        send_plain(sps_pkg::CMD_STOP);
        send_plain(sps_pkg::CMD_TICK);
        send_item(sps_pkg::CMD_WRITE, 4'd15, 7'd0, 6'd0, 6'd1, 14'd9999);
        send_plain(sps_pkg::CMD_START);
        send_plain(sps_pkg::CMD_STOP);

        random_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_goal) begin
            if (phase < 5) total = extremes[phase];
            else total = sps_pkg::TOTAL_W'($urandom_range(0, 31));
            drain();
            write_total(total);
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            rx_no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) run_program();
            phase++;
        end

        drain();
        $display("Ran %0d commands under %0d segment-count settings, %0d results checked.",
                 items_sent, board.settings, board.results);
        $display("Seen %0d segment advances and %0d completed programs.",
                 board.advances, board.completions);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Accept results with random back-pressure and two long holds
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = rx_no_gaps ? 0 : $urandom_range(0, IDLE_MAX);
            if (taken == 400 || taken == 1100) gap = STALL_LEN;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_status(m_axis_tdata);
            taken++;
            @(negedge i_clk);
        end
    end

    // Abort when no transfer happens on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
